// ----- hdl/bawsamp_pkg.sv -----
package bawsamp_pkg;

  localparam int FRACTION_BITS_DEF  = 8;
  localparam int COORD_INT_BITS_DEF = 16;

  localparam int BYTE_W      = 8;
  localparam int CHAN_W      = 16;
  localparam int DIM_W       = 16;
  localparam int PIX_W       = 64;
  localparam int NUM_COLORS  = 3;
  localparam int NUM_CORNERS = 4;
  localparam int ALPHA_LANE  = 3;

  localparam int COLOR_RED   = 0;
  localparam int COLOR_GREEN = 1;
  localparam int COLOR_BLUE  = 2;

  localparam int CORNER_TL = 0;
  localparam int CORNER_TR = 1;
  localparam int CORNER_BL = 2;
  localparam int CORNER_BR = 3;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_WIDE_CHANNELS = 2'd2
  } cfg_reg_t;

  // 8-bit channel in the low byte scaled by 257 is the byte repeated
  function automatic logic [CHAN_W-1:0] expand_chan(input logic [CHAN_W-1:0] lane,
                                                    input logic wide);
    logic [CHAN_W-1:0] res;
    if (wide) begin
      res = lane;
    end else begin
      res = {lane[BYTE_W-1:0], lane[BYTE_W-1:0]};
    end
    return res;
  endfunction

endpackage

// ----- hdl/bawsamp_lane.sv -----
module bawsamp_lane #(
  parameter int FRACTION_BITS = bawsamp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     wide,
  input  logic [FRACTION_BITS:0]                   fx,
  input  logic [FRACTION_BITS:0]                   fy,
  input  logic [bawsamp_pkg::PIX_W-1:0]            pixel,
  output logic [bawsamp_pkg::CHAN_W+2*FRACTION_BITS-1:0]   aw,
  output logic [2*bawsamp_pkg::CHAN_W+2*FRACTION_BITS-1:0] vaw [bawsamp_pkg::NUM_COLORS],
  output logic [bawsamp_pkg::CHAN_W+2*FRACTION_BITS-1:0]   vw  [bawsamp_pkg::NUM_COLORS]
);
  import bawsamp_pkg::*;

  localparam int FAC_W = FRACTION_BITS + 1;
  localparam int WGT_W = 2 * FRACTION_BITS + 1;
  localparam int AW    = CHAN_W + 2 * FRACTION_BITS;
  localparam int NW    = 2 * CHAN_W + 2 * FRACTION_BITS;
  localparam int VA_W  = 2 * CHAN_W;

  logic [2*FAC_W-1:0] w_full;
  logic [CHAN_W-1:0]  a_in;
  logic [CHAN_W-1:0]  v_in [NUM_COLORS];

  logic [WGT_W-1:0]   w_r;
  logic [CHAN_W-1:0]  a_r;
  logic [CHAN_W-1:0]  v_r  [NUM_COLORS];
  logic [VA_W-1:0]    va_r [NUM_COLORS];

  logic [AW:0]        aw_full;
  logic [NW:0]        vaw_full [NUM_COLORS];
  logic [AW:0]        vw_full  [NUM_COLORS];

  logic [AW-1:0]      aw_r;
  logic [NW-1:0]      vaw_r [NUM_COLORS];
  logic [AW-1:0]      vw_r  [NUM_COLORS];

  assign w_full = (2*FAC_W)'(fx) * (2*FAC_W)'(fy);
  assign a_in   = expand_chan(pixel[ALPHA_LANE*CHAN_W +: CHAN_W], wide);

  always_comb begin
    for (int c = 0; c < NUM_COLORS; c++) begin
      v_in[c] = expand_chan(pixel[c*CHAN_W +: CHAN_W], wide);
    end
  end

  // stage 1: corner weight, color times alpha
  always_ff @(posedge clk) begin
    w_r <= w_full[WGT_W-1:0];
    a_r <= a_in;
    for (int c = 0; c < NUM_COLORS; c++) begin
      v_r[c]  <= v_in[c];
      va_r[c] <= VA_W'(v_in[c]) * VA_W'(a_in);
    end
  end

  always_comb begin
    aw_full = (AW+1)'(a_r) * (AW+1)'(w_r);
    for (int c = 0; c < NUM_COLORS; c++) begin
      vaw_full[c] = (NW+1)'(va_r[c]) * (NW+1)'(w_r);
      vw_full[c]  = (AW+1)'(v_r[c]) * (AW+1)'(w_r);
    end
  end

  // stage 2: weighted terms
  always_ff @(posedge clk) begin
    aw_r <= aw_full[AW-1:0];
    for (int c = 0; c < NUM_COLORS; c++) begin
      vaw_r[c] <= vaw_full[c][NW-1:0];
      vw_r[c]  <= vw_full[c][AW-1:0];
    end
  end

  assign aw  = aw_r;
  assign vaw = vaw_r;
  assign vw  = vw_r;

endmodule

// ----- hdl/bawsamp_div.sv -----
module bawsamp_div #(
  parameter int NUM_W = 2 * bawsamp_pkg::CHAN_W + 2 * bawsamp_pkg::FRACTION_BITS_DEF,
  parameter int DEN_W = bawsamp_pkg::CHAN_W + 2 * bawsamp_pkg::FRACTION_BITS_DEF,
  parameter int QUO_W = bawsamp_pkg::CHAN_W
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);
  // restoring divider, one quotient bit per stage, num < den * 2^QUO_W;
  // last stage rounds to nearest (ties up) and saturates
  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [NUM_W-1:0] trial;
    logic [NUM_W:0]   diff;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = NUM_W'(den_in) << B;
    assign diff  = {1'b0, rem_in} - {1'b0, trial};

    always_ff @(posedge clk) begin
      den_r[k] <= den_in;
      if (diff[NUM_W]) begin
        rem_r[k] <= rem_in;
        quo_r[k] <= quo_in;
      end else begin
        rem_r[k] <= diff[NUM_W-1:0];
        quo_r[k] <= quo_in | (QUO_W'(1) << B);
      end
    end
  end

  logic [DEN_W:0]   rem2;
  logic             rnd;
  logic [QUO_W:0]   quo_rnd;
  logic [QUO_W-1:0] quo_nxt;
  logic [QUO_W-1:0] quo_out_r;

  always_comb begin
    rem2    = {rem_r[QUO_W-1][DEN_W-1:0], 1'b0};
    rnd     = rem2 >= {1'b0, den_r[QUO_W-1]};
    quo_rnd = {1'b0, quo_r[QUO_W-1]} + (QUO_W+1)'(rnd);
    quo_nxt = quo_rnd[QUO_W] ? '1 : quo_rnd[QUO_W-1:0];
  end

  always_ff @(posedge clk) begin
    quo_out_r <= quo_nxt;
  end

  assign quo = quo_out_r;

endmodule

// ----- hdl/bilinear_alpha_weighted_sampler.sv -----
// Pipeline: 2 lane stages, 2 merge stages, 16 divider stages, 1 rounding stage.
// Throughput: one sample per clock; busy stays low, the pipeline never stalls
//   and the receiver cannot hold results off.
// Reset (rst_n low, synchronous): pipeline valids cleared, image 1x1, 8-bit channels.
module bilinear_alpha_weighted_sampler #(
  parameter int FRACTION_BITS  = bawsamp_pkg::FRACTION_BITS_DEF,
  parameter int COORD_INT_BITS = bawsamp_pkg::COORD_INT_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  output logic                                       busy,
  input  logic signed [COORD_INT_BITS+FRACTION_BITS-1:0] in_pos_x,
  input  logic signed [COORD_INT_BITS+FRACTION_BITS-1:0] in_pos_y,
  input  logic [bawsamp_pkg::PIX_W-1:0]              in_pixel_top_left,
  input  logic [bawsamp_pkg::PIX_W-1:0]              in_pixel_top_right,
  input  logic [bawsamp_pkg::PIX_W-1:0]              in_pixel_bottom_left,
  input  logic [bawsamp_pkg::PIX_W-1:0]              in_pixel_bottom_right,
  output logic                                       out_strobe,
  output logic [bawsamp_pkg::CHAN_W-1:0]             out_red_out,
  output logic [bawsamp_pkg::CHAN_W-1:0]             out_green_out,
  output logic [bawsamp_pkg::CHAN_W-1:0]             out_blue_out,
  output logic [bawsamp_pkg::CHAN_W-1:0]             out_alpha_out,
  output logic                                       out_sample_valid,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [bawsamp_pkg::CFG_ADDR_W-1:0]         paddr,
  input  logic [bawsamp_pkg::CFG_DATA_W-1:0]         pwdata,
  output logic [bawsamp_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                       pready
);
  import bawsamp_pkg::*;

  localparam int POS_W     = COORD_INT_BITS + FRACTION_BITS;
  localparam int FAC_W     = FRACTION_BITS + 1;
  localparam int AW        = CHAN_W + 2 * FRACTION_BITS;
  localparam int NW        = 2 * CHAN_W + 2 * FRACTION_BITS;
  localparam int CW        = POS_W + DIM_W;
  localparam int LANE_LAT  = 2;
  localparam int MERGE_LAT = 2;
  localparam int DIV_LAT   = CHAN_W + 1;
  localparam int LAT       = LANE_LAT + MERGE_LAT + DIV_LAT;
  localparam int M2_IDX    = LANE_LAT + MERGE_LAT - 1;

  // configuration registers
  logic [DIM_W-1:0] img_w_r, img_w_nxt;
  logic [DIM_W-1:0] img_h_r, img_h_nxt;
  logic             wide_r, wide_nxt;
  logic             cfg_wr;
  cfg_reg_t         cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    img_w_nxt = img_w_r;
    img_h_nxt = img_h_r;
    wide_nxt  = wide_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:   img_w_nxt = pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  img_h_nxt = pwdata[DIM_W-1:0];
        REG_WIDE_CHANNELS: wide_nxt  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= DIM_W'(1);
      img_h_r <= DIM_W'(1);
      wide_r  <= 1'b0;
    end else begin
      img_w_r <= img_w_nxt;
      img_h_r <= img_h_nxt;
      wide_r  <= wide_nxt;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:   prdata = CFG_DATA_W'(img_w_r);
      REG_IMAGE_HEIGHT:  prdata = CFG_DATA_W'(img_h_r);
      REG_WIDE_CHANNELS: prdata = CFG_DATA_W'(wide_r);
      default:           prdata = '0;
    endcase
  end

  // bounds check and fractional weights
  logic [CW-1:0]    lim_x, lim_y, mag_x, mag_y;
  logic             in_x, in_y, ok;
  logic [FAC_W-1:0] one, tx, ty, inv_tx, inv_ty;
  logic [PIX_W-1:0] pix [NUM_CORNERS];

  always_comb begin
    lim_x  = CW'(img_w_r - DIM_W'(1)) << FRACTION_BITS;
    lim_y  = CW'(img_h_r - DIM_W'(1)) << FRACTION_BITS;
    mag_x  = CW'(in_pos_x[POS_W-2:0]);
    mag_y  = CW'(in_pos_y[POS_W-2:0]);
    in_x   = !in_pos_x[POS_W-1] && (img_w_r != '0) && (mag_x <= lim_x);
    in_y   = !in_pos_y[POS_W-1] && (img_h_r != '0) && (mag_y <= lim_y);
    ok     = in_x && in_y;
    one    = FAC_W'(1) << FRACTION_BITS;
    tx     = FAC_W'(in_pos_x[FRACTION_BITS-1:0]);
    ty     = FAC_W'(in_pos_y[FRACTION_BITS-1:0]);
    inv_tx = one - tx;
    inv_ty = one - ty;
  end

  assign pix[CORNER_TL] = in_pixel_top_left;
  assign pix[CORNER_TR] = in_pixel_top_right;
  assign pix[CORNER_BL] = in_pixel_bottom_left;
  assign pix[CORNER_BR] = in_pixel_bottom_right;

  // corner lanes; an outside sample gets zero weights everywhere
  logic [AW-1:0] aw_l  [NUM_CORNERS];
  logic [NW-1:0] vaw_l [NUM_CORNERS][NUM_COLORS];
  logic [AW-1:0] vw_l  [NUM_CORNERS][NUM_COLORS];

  for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_lane
    localparam bit RIGHT  = (c % 2) != 0;
    localparam bit BOTTOM = (c / 2) != 0;
    logic [FAC_W-1:0] fx, fy;

    assign fx = !ok ? '0 : (RIGHT  ? tx : inv_tx);
    assign fy = !ok ? '0 : (BOTTOM ? ty : inv_ty);

    bawsamp_lane #(
      .FRACTION_BITS(FRACTION_BITS)
    ) u_lane (
      .clk   (clk),
      .wide  (wide_r),
      .fx    (fx),
      .fy    (fy),
      .pixel (pix[c]),
      .aw    (aw_l[c]),
      .vaw   (vaw_l[c]),
      .vw    (vw_l[c])
    );
  end

  // merge 1: sums over corners
  logic [AW+1:0] asum_full;
  logic [NW+1:0] acca_full [NUM_COLORS];
  logic [AW+1:0] accp_full [NUM_COLORS];
  logic [AW-1:0] asum_r;
  logic [NW-1:0] acca_r [NUM_COLORS];
  logic [AW-1:0] accp_r [NUM_COLORS];

  always_comb begin
    asum_full = '0;
    for (int k = 0; k < NUM_COLORS; k++) begin
      acca_full[k] = '0;
      accp_full[k] = '0;
    end
    for (int c = 0; c < NUM_CORNERS; c++) begin
      asum_full = asum_full + (AW+2)'(aw_l[c]);
      for (int k = 0; k < NUM_COLORS; k++) begin
        acca_full[k] = acca_full[k] + (NW+2)'(vaw_l[c][k]);
        accp_full[k] = accp_full[k] + (AW+2)'(vw_l[c][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    asum_r <= asum_full[AW-1:0];
    for (int k = 0; k < NUM_COLORS; k++) begin
      acca_r[k] <= acca_full[k][NW-1:0];
      accp_r[k] <= accp_full[k][AW-1:0];
    end
  end

  // merge 2: alpha, divider operands
  logic              asum_nz;
  logic [CHAN_W:0]   alpha_rnd;
  logic [CHAN_W-1:0] alpha_nxt;
  logic [AW-1:0]     total;
  logic [AW-1:0]     den_r;
  logic [NW-1:0]     num_r [NUM_COLORS];
  logic [CHAN_W-1:0] alpha_r;

  always_comb begin
    asum_nz   = asum_r != '0;
    alpha_rnd = {1'b0, asum_r[AW-1 -: CHAN_W]}
                + (CHAN_W+1)'(asum_r[2*FRACTION_BITS-1]);
    alpha_nxt = alpha_rnd[CHAN_W] ? '1 : alpha_rnd[CHAN_W-1:0];
    total     = AW'(1) << (2 * FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    alpha_r <= alpha_nxt;
    den_r   <= asum_nz ? asum_r : total;
    for (int k = 0; k < NUM_COLORS; k++) begin
      num_r[k] <= asum_nz ? acca_r[k] : NW'(accp_r[k]);
    end
  end

  logic [CHAN_W-1:0] quo_d [NUM_COLORS];

  for (genvar k = 0; k < NUM_COLORS; k++) begin : g_div
    bawsamp_div #(
      .NUM_W (NW),
      .DEN_W (AW),
      .QUO_W (CHAN_W)
    ) u_div (
      .clk (clk),
      .num (num_r[k]),
      .den (den_r),
      .quo (quo_d[k])
    );
  end

  // side pipes
  logic [LAT-1:0]    vld_r, vld_nxt;
  logic              okp_r   [LAT];
  logic [CHAN_W-1:0] alpha_d_r [DIV_LAT];

  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    okp_r[0]     <= ok;
    alpha_d_r[0] <= alpha_r;
    for (int i = 1; i < LAT; i++) begin
      okp_r[i] <= okp_r[i-1];
    end
    for (int i = 1; i < DIV_LAT; i++) begin
      alpha_d_r[i] <= alpha_d_r[i-1];
    end
  end

  assign out_strobe       = vld_r[LAT-1];
  assign out_sample_valid = okp_r[LAT-1];
  assign out_red_out      = quo_d[COLOR_RED];
  assign out_green_out    = quo_d[COLOR_GREEN];
  assign out_blue_out     = quo_d[COLOR_BLUE];
  assign out_alpha_out    = alpha_d_r[DIV_LAT-1];

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_sample_valid |->
      out_red_out == '0 && out_green_out == '0 && out_blue_out == '0 &&
      out_alpha_out == '0)
    else $error("outside sample gave nonzero result");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[M2_IDX] |-> den_r != '0)
    else $error("divider fed a zero denominator");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(LAT) out_strobe)
    else $error("accepted transfer produced no result");

endmodule

// ----- sim/sample_checker.sv -----
`timescale 1ns / 100ps
module sample_checker #(
  parameter int POS_W = bawsamp_pkg::COORD_INT_BITS_DEF + bawsamp_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic signed [POS_W-1:0]            pos_x,
  input  logic signed [POS_W-1:0]            pos_y,
  input  logic [bawsamp_pkg::PIX_W-1:0]      pix_tl,
  input  logic [bawsamp_pkg::PIX_W-1:0]      pix_tr,
  input  logic [bawsamp_pkg::PIX_W-1:0]      pix_bl,
  input  logic [bawsamp_pkg::PIX_W-1:0]      pix_br,
  input  logic                               strobe,
  input  logic [bawsamp_pkg::CHAN_W-1:0]     red,
  input  logic [bawsamp_pkg::CHAN_W-1:0]     green,
  input  logic [bawsamp_pkg::CHAN_W-1:0]     blue,
  input  logic [bawsamp_pkg::CHAN_W-1:0]     alpha,
  input  logic                               sample_valid,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [bawsamp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bawsamp_pkg::CFG_DATA_W-1:0] pwdata,
  output int                                 mismatch_count,
  output int                                 samples_in_flight
);
  import bawsamp_pkg::*;

  localparam int FB = FRACTION_BITS_DEF;
  localparam logic [63:0] ONE = 64'd1 << FB;

  typedef logic [63:0] u64_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              valid;
  } sample_t;

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic             wide_reg;
  sample_t          expected_samples[$];
  int               errors = 0;

  function automatic u64_t lane_value(logic [PIX_W-1:0] pix, int lane, logic wide);
    u64_t v;
    v = 64'(pix[lane*CHAN_W +: CHAN_W]);
    if (!wide) begin
      v = (v & 64'hFF) * 64'd257;
    end
    return v;
  endfunction

  function automatic logic [CHAN_W-1:0] round_div(u64_t num, u64_t den);
    u64_t q;
    u64_t r;
    q = num / den;
    r = num % den;
    if (r >= den - r) begin
      q = q + 1;
    end
    return (q > 64'd65535) ? 16'hFFFF : q[CHAN_W-1:0];
  endfunction

  function automatic logic in_bounds(logic signed [POS_W-1:0] p, logic [DIM_W-1:0] size);
    longint lim;
    if (size == 0 || p < 0) begin
      return 1'b0;
    end
    lim = (longint'(size) - 1) * longint'(ONE);
    return longint'(p) <= lim;
  endfunction

  function automatic sample_t interpolate_sample(logic signed [POS_W-1:0] px,
                                                 logic signed [POS_W-1:0] py,
                                                 logic [PIX_W-1:0] tl, logic [PIX_W-1:0] tr,
                                                 logic [PIX_W-1:0] bl, logic [PIX_W-1:0] br);
    sample_t s;
    logic [PIX_W-1:0] pix [NUM_CORNERS];
    u64_t tx, ty, asum, acc, v;
    u64_t wt [NUM_CORNERS];
    u64_t al [NUM_CORNERS];
    logic [CHAN_W-1:0] col [NUM_COLORS];
    s = '0;
    if (!in_bounds(px, width_reg) || !in_bounds(py, height_reg)) begin
      return s;
    end
    pix[CORNER_TL] = tl;
    pix[CORNER_TR] = tr;
    pix[CORNER_BL] = bl;
    pix[CORNER_BR] = br;
    tx = 64'(px[FB-1:0]);
    ty = 64'(py[FB-1:0]);
    wt[CORNER_TL] = (ONE - tx) * (ONE - ty);
    wt[CORNER_TR] = tx * (ONE - ty);
    wt[CORNER_BL] = (ONE - tx) * ty;
    wt[CORNER_BR] = tx * ty;
    asum = 0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      al[i] = lane_value(pix[i], ALPHA_LANE, wide_reg);
      asum = asum + al[i] * wt[i];
    end
    s.alpha = round_div(asum, ONE * ONE);
    for (int c = 0; c < NUM_COLORS; c++) begin
      acc = 0;
      for (int i = 0; i < NUM_CORNERS; i++) begin
        v = lane_value(pix[i], c, wide_reg);
        acc = acc + ((asum != 0) ? v * al[i] * wt[i] : v * wt[i]);
      end
      col[c] = round_div(acc, (asum != 0) ? asum : ONE * ONE);
    end
    s.red   = col[COLOR_RED];
    s.green = col[COLOR_GREEN];
    s.blue  = col[COLOR_BLUE];
    s.valid = 1'b1;
    return s;
  endfunction

  always @(posedge clk) begin
    sample_t want;
    sample_t got;
    if (!rst_n) begin
      width_reg  = 16'd1;
      height_reg = 16'd1;
      wide_reg   = 1'b0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[3:2]))
          REG_IMAGE_WIDTH:   width_reg  = pwdata[DIM_W-1:0];
          REG_IMAGE_HEIGHT:  height_reg = pwdata[DIM_W-1:0];
          REG_WIDE_CHANNELS: wide_reg   = pwdata[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_samples.insert(expected_samples.size(),
                                interpolate_sample(pos_x, pos_y, pix_tl, pix_tr,
                                                   pix_bl, pix_br));
      end
      if (strobe) begin
        got = '{red: red, green: green, blue: blue, alpha: alpha, valid: sample_valid};
        if (expected_samples.size() == 0) begin
          if (errors < 10) begin
            $display("%0t: result with no transfer pending: r=%h g=%h b=%h a=%h v=%b",
                     $realtime, red, green, blue, alpha, sample_valid);
          end
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.alpha !== want.alpha ||
              got.valid !== want.valid) begin
            if (errors < 10) begin
              $display("%0t: mismatch exp r=%h g=%h b=%h a=%h v=%b got r=%h g=%h b=%h a=%h v=%b",
                       $realtime, want.red, want.green, want.blue, want.alpha, want.valid,
                       got.red, got.green, got.blue, got.alpha, got.valid);
            end
            errors++;
          end
        end
      end
    end
    mismatch_count    <= errors;
    samples_in_flight <= expected_samples.size();
  end

endmodule

// ----- sim/bilinear_alpha_weighted_sampler_test.sv -----
`timescale 1ns / 100ps
module bilinear_alpha_weighted_sampler_test;
  import bawsamp_pkg::*;

  localparam int POS_W   = COORD_INT_BITS_DEF + FRACTION_BITS_DEF;
  localparam int LATENCY = 21;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [PIX_W-1:0]        pix_tl;
  logic [PIX_W-1:0]        pix_tr;
  logic [PIX_W-1:0]        pix_bl;
  logic [PIX_W-1:0]        pix_br;
  logic                    out_strobe;
  logic [CHAN_W-1:0]       out_red;
  logic [CHAN_W-1:0]       out_green;
  logic [CHAN_W-1:0]       out_blue;
  logic [CHAN_W-1:0]       out_alpha;
  logic                    out_valid;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CFG_ADDR_W-1:0]   paddr;
  logic [CFG_DATA_W-1:0]   pwdata;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;
  int                      mismatch_count;
  int                      samples_in_flight;
  logic                    idle_on;

  bilinear_alpha_weighted_sampler dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_pos_x              (pos_x),
    .in_pos_y              (pos_y),
    .in_pixel_top_left     (pix_tl),
    .in_pixel_top_right    (pix_tr),
    .in_pixel_bottom_left  (pix_bl),
    .in_pixel_bottom_right (pix_br),
    .out_strobe            (out_strobe),
    .out_red_out           (out_red),
    .out_green_out         (out_green),
    .out_blue_out          (out_blue),
    .out_alpha_out         (out_alpha),
    .out_sample_valid      (out_valid),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  sample_checker #(.POS_W(POS_W)) checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .pix_tl            (pix_tl),
    .pix_tr            (pix_tr),
    .pix_bl            (pix_bl),
    .pix_br            (pix_br),
    .strobe            (out_strobe),
    .red               (out_red),
    .green             (out_green),
    .blue              (out_blue),
    .alpha             (out_alpha),
    .sample_valid      (out_valid),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .mismatch_count    (mismatch_count),
    .samples_in_flight (samples_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [PIX_W-1:0] rgba(logic [15:0] r, logic [15:0] g,
                                            logic [15:0] b, logic [15:0] a);
    return {a, b, g, r};
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [POS_W-1:0] pick_coord(int unsigned size);
    int unsigned mode;
    int unsigned hi;
    int unsigned ip;
    int unsigned fr;
    longint v;
    mode = $urandom_range(99);
    if (size != 0 && mode < 75) begin
      hi = (size - 1 > 32767) ? 32767 : size - 1;
      ip = $urandom_range(hi, 0);
      case ($urandom_range(9))
        0, 1:    fr = 0;
        2:       fr = 128;
        default: fr = $urandom_range(255);
      endcase
      if (ip == size - 1) begin
        fr = 0;
      end
      v = longint'(ip) * 256 + fr;
    end else if (mode < 88) begin
      case ($urandom_range(3))
        0:       v = (longint'(size) - 1) * 256;
        1:       v = (longint'(size) - 1) * 256 + 1;
        2:       v = -1;
        default: v = -longint'($urandom_range(8388608, 1));
      endcase
    end else begin
      v = longint'($urandom);
    end
    return v[POS_W-1:0];
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 15) return 1;
    if (r < 25) return 65535;
    if (r < 65) return $urandom_range(64, 1);
    return $urandom_range(65535, 1);
  endfunction

  task automatic send_sample(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                             logic [PIX_W-1:0] tl, logic [PIX_W-1:0] tr,
                             logic [PIX_W-1:0] bl, logic [PIX_W-1:0] br);
    while (idle_on && $urandom_range(99) < 32) begin
      start <= 1'b0;
      @(posedge clk);
    end
    pos_x  <= x;
    pos_y  <= y;
    pix_tl <= tl;
    pix_tr <= tr;
    pix_bl <= bl;
    pix_br <= br;
    start  <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random_sample(int unsigned w, int unsigned h);
    logic [PIX_W-1:0] px [NUM_CORNERS];
    int unsigned mode;
    mode = $urandom_range(99);
    for (int i = 0; i < NUM_CORNERS; i++) begin
      px[i] = rand_pixel();
      if (mode < 15) begin
        px[i][ALPHA_LANE*CHAN_W +: CHAN_W] = '0;
      end else if (mode < 25) begin
        px[i][ALPHA_LANE*CHAN_W +: CHAN_W] = '1;
      end else if (mode < 40 && $urandom_range(1) == 1) begin
        px[i][ALPHA_LANE*CHAN_W +: CHAN_W] = '0;
      end
    end
    send_sample(pick_coord(w), pick_coord(h), px[CORNER_TL], px[CORNER_TR],
                px[CORNER_BL], px[CORNER_BR]);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (samples_in_flight != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int unsigned w, int unsigned h, logic wide);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_WIDE_CHANNELS, {31'd0, wide});
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    rst_n   = 1'b0;
    start   = 1'b0;
    pos_x   = '0;
    pos_y   = '0;
    pix_tl  = '0;
    pix_tr  = '0;
    pix_bl  = '0;
    pix_br  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    idle_on = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: 1x1 image, 8-bit lanes
    send_sample(0, 0, rgba(16'hAB12, 16'h34CD, 16'hFF00, 16'h1280), rand_pixel(),
                rand_pixel(), rand_pixel());
    send_sample(0, 0, '1, '1, '1, '1);
    send_sample(0, 0, '0, '0, '0, '0);
    send_sample(1, 0, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
    send_sample(0, 1, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
    send_sample(-1, 0, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
    send_sample({1'b1, {(POS_W-1){1'b0}}}, {1'b0, {(POS_W-1){1'b1}}},
                rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
    send_sample(0, 0, rgba(16'h0011, 16'h0022, 16'h0033, 16'h0000),
                rgba(16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF), rand_pixel(), rand_pixel());

    configure(65535, 65535, 1'b1);
    send_sample({1'b0, {(POS_W-1){1'b1}}}, {1'b0, {(POS_W-1){1'b1}}}, '1, '1, '1, '1);
    send_sample({1'b0, {(POS_W-1){1'b1}}}, {1'b0, {(POS_W-1){1'b1}}},
                rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
    // half-way weights, alpha tie rounds up
    send_sample(128, 128, rgba(16'h0001, 16'h0000, 16'hFFFF, 16'h0002), '0, '0, '0);
    send_sample(128, 128, rgba(16'h1234, 16'h5678, 16'h9ABC, 16'h0000),
                rgba(16'hFFFF, 16'h0000, 16'h8000, 16'h0000),
                rgba(16'h0000, 16'hFFFF, 16'h0001, 16'h0000),
                rgba(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000));
    send_sample(256, 0, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
    send_sample(255, 255, rgba(16'hFFFF, 16'h8000, 16'h0001, 16'hFFFF),
                rgba(16'h1111, 16'h2222, 16'h3333, 16'h0000), rand_pixel(), rand_pixel());
    send_sample(0, 0, '0, '0, '0, '0);

    configure(0, 3, 1'b0);
    send_sample(0, 0, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
    send_sample(256, 256, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());

    configure(4, 0, 1'b1);
    send_sample(0, 0, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());

    configure(2, 2, 1'b0);
    send_sample(256, 256, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
    send_sample(257, 0, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
    send_sample(0, 512, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
    send_sample(128, 255, rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          w = 1;
          h = 1;
        end
        1: begin
          w = 65535;
          h = 65535;
        end
        default: begin
          w = pick_size();
          h = pick_size();
        end
      endcase
      configure(w, h, ph[0]);
      idle_on = (ph != 3);
      for (int n = 0; n < 250; n++) begin
        send_random_sample(w, h);
      end
    end
    idle_on = 1'b1;

    start <= 1'b0;
    @(posedge clk);
    while (samples_in_flight != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && samples_in_flight == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
